// File: sv/cantxq_pkg.sv
// ----------------------------------------------------------------------------
// cantxq_pkg
// Shared types and constants for the CAN transmit frame queue.
// ----------------------------------------------------------------------------
package cantxq_pkg;

    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 5;
    localparam int ENTRY_W = ID_W + LEN_W + DATA_W;

    // request opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // extended data page bit of the J1939 identifier
    localparam logic EDP_VALUE = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic take_push;
        logic take_send_hit;
        logic take_send_miss;
        logic load_frame;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ring_empty;
    } status_t;

endpackage

// File: sv/cantxq_ram.sv
// ----------------------------------------------------------------------------
// cantxq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cantxq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/cantxq_ctrl.sv
// ----------------------------------------------------------------------------
// cantxq_ctrl
// Request sequencer: accepts one request, waits for the ring read on a send
// that finds a frame while the transmitter is idle, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module cantxq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic                s_tx_idle,
    output logic                m_valid,
    input  logic                m_ready,
    input  cantxq_pkg::status_t status,
    output cantxq_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == cantxq_pkg::OP_PUSH) begin
                        cmd.take_push = 1'b1;
                        state_next    = ST_OUT;
                    end else if (!status.ring_empty && s_tx_idle) begin
                        cmd.take_send_hit = 1'b1;
                        state_next        = ST_READ;
                    end else begin
                        cmd.take_send_miss = 1'b1;
                        state_next         = ST_OUT;
                    end
                end
            end
            ST_READ: begin
                cmd.load_frame = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/cantxq_datapath.sv
// ----------------------------------------------------------------------------
// cantxq_datapath
// Frame assembly, ring pointers, frame store and result registers.
// ----------------------------------------------------------------------------
module cantxq_datapath #(
    parameter int RING_DEPTH  = 32,
    parameter int FRAME_BYTES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cantxq_pkg::cmd_t                    cmd,
    output cantxq_pkg::status_t                 status,
    input  logic [7:0]                          s_source_addr,
    input  logic [7:0]                          s_pdu_specific,
    input  logic [7:0]                          s_pdu_format,
    input  logic                                s_data_page,
    input  logic [2:0]                          s_priority_req,
    input  logic [7:0]                          s_payload_byte,
    input  logic                                s_last_byte,
    input  logic                                s_tx_accepts,
    output logic                                m_frame_valid,
    output logic [cantxq_pkg::ID_W-1:0]         m_frame_id,
    output logic [cantxq_pkg::LEN_W-1:0]        m_frame_length,
    output logic [cantxq_pkg::DATA_W-1:0]       m_frame_bytes,
    output logic [cantxq_pkg::COUNT_W-1:0]      m_queue_count
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [cantxq_pkg::LEN_W-1:0] LEN_FULL = cantxq_pkg::LEN_W'(FRAME_BYTES);

    logic [PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PTR_W-1:0] wp_inc, rp_inc, rp_wrap;
    logic [cantxq_pkg::DATA_W-1:0] asm_bytes_reg, asm_bytes_next, asm_filled;
    logic [cantxq_pkg::LEN_W-1:0]  asm_count_reg, asm_count_next, asm_count_inc;
    logic                          commit;
    logic [cantxq_pkg::ID_W-1:0]   push_id;
    logic [cantxq_pkg::ENTRY_W-1:0] rd_data;
    logic [CNT_W-1:0]              ring_count;

    logic                          frame_valid_reg;
    logic [cantxq_pkg::ID_W-1:0]   frame_id_reg;
    logic [cantxq_pkg::LEN_W-1:0]  frame_len_reg;
    logic [cantxq_pkg::DATA_W-1:0] frame_bytes_reg;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign wp_inc = ring_next(wp_reg);
    assign rp_inc = ring_next(rp_reg);

    // byte lane insert at the current fill position
    always_comb begin
        asm_filled    = asm_bytes_reg;
        asm_count_inc = asm_count_reg;
        if (asm_count_reg < LEN_FULL) begin
            asm_count_inc = asm_count_reg + 1'b1;
            for (int i = 0; i < 8; i++) begin
                if (asm_count_reg == cantxq_pkg::LEN_W'(i)) begin
                    asm_filled[i*8 +: 8] = asm_bytes_reg[i*8 +: 8] | s_payload_byte;
                end
            end
        end
    end

    assign commit  = cmd.take_push && ((asm_count_inc >= LEN_FULL) || s_last_byte);
    assign push_id = {s_priority_req, cantxq_pkg::EDP_VALUE, s_data_page,
                      s_pdu_format, s_pdu_specific, s_source_addr};

    // a commit that catches up with the oldest frame drops it
    assign rp_wrap = (wp_inc == rp_reg) ? rp_inc : rp_reg;

    always_comb begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        asm_bytes_next = asm_bytes_reg;
        asm_count_next = asm_count_reg;
        if (cmd.take_push) begin
            if (commit) begin
                wp_next        = wp_inc;
                rp_next        = rp_wrap;
                asm_bytes_next = '0;
                asm_count_next = '0;
            end else begin
                asm_bytes_next = asm_filled;
                asm_count_next = asm_count_inc;
            end
        end else if (cmd.take_send_hit && s_tx_accepts) begin
            rp_next = rp_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            asm_bytes_reg <= '0;
            asm_count_reg <= '0;
        end else begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            asm_bytes_reg <= asm_bytes_next;
            asm_count_reg <= asm_count_next;
        end
    end

    cantxq_ram #(
        .WIDTH (cantxq_pkg::ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (wp_reg),
        .wr_data ({push_id, asm_count_inc, asm_filled}),
        .rd_en   (cmd.take_send_hit),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.take_push || cmd.take_send_miss || cmd.take_send_hit) begin
            frame_valid_reg <= cmd.take_send_hit;
            frame_id_reg    <= '0;
            frame_len_reg   <= '0;
            frame_bytes_reg <= '0;
        end else if (cmd.load_frame) begin
            {frame_id_reg, frame_len_reg, frame_bytes_reg} <= rd_data;
        end
    end

    assign ring_count = (wp_reg >= rp_reg)
                      ? CNT_W'(wp_reg) - CNT_W'(rp_reg)
                      : CNT_W'(wp_reg) + CNT_W'(RING_DEPTH) - CNT_W'(rp_reg);

    assign status.ring_empty = (wp_reg == rp_reg);
    assign m_frame_valid     = frame_valid_reg;
    assign m_frame_id        = frame_id_reg;
    assign m_frame_length    = frame_len_reg;
    assign m_frame_bytes     = frame_bytes_reg;
    assign m_queue_count     = cantxq_pkg::COUNT_W'(ring_count);

`ifndef SYNTHESIS
    a_asm_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        asm_count_reg < LEN_FULL)
        else $error("assembly count reached frame size without commit");

    a_commit_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (wp_reg != rp_reg))
        else $error("ring empty right after a commit");

    a_load_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_frame |-> $past(cmd.take_send_hit))
        else $error("frame load without ring read");

    a_loaded_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_frame |=> (frame_len_reg != '0) && frame_valid_reg)
        else $error("offered frame has no data bytes");

    a_miss_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take_send_miss || cmd.take_push) |=> !frame_valid_reg)
        else $error("frame offered on push or missed send");
`endif

endmodule

// File: sv/can_tx_frame_segmenting_queue_core.sv
// ----------------------------------------------------------------------------
// can_tx_frame_segmenting_queue_core
// CAN transmit queue: gathers J1939 payload bytes into frames and offers the
// oldest stored frame to the transmitter.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   op, header fields, byte, tx status
//  m_       out  m_valid / m_ready   frame valid, id, length, bytes, count
//
//  a push or missed send presents its result in the cycle after accept; a
//  send that reads the ring passes through ST_READ before ST_OUT
//  (registered read of the frame store); s_ready stays low until the
//  result has been taken
//  a stall on m_ready holds the result and blocks new requests
//  reset clears pointers and the assembly buffer; the store is not cleared
// ----------------------------------------------------------------------------
module can_tx_frame_segmenting_queue_core #(
    parameter int RING_DEPTH  = 32,
    parameter int FRAME_BYTES = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [7:0]                      s_source_addr,
    input  logic [7:0]                      s_pdu_specific,
    input  logic [7:0]                      s_pdu_format,
    input  logic                            s_data_page,
    input  logic [2:0]                      s_priority_req,
    input  logic [7:0]                      s_payload_byte,
    input  logic                            s_last_byte,
    input  logic                            s_tx_idle,
    input  logic                            s_tx_accepts,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_frame_valid,
    output logic [cantxq_pkg::ID_W-1:0]     m_frame_id,
    output logic [cantxq_pkg::LEN_W-1:0]    m_frame_length,
    output logic [cantxq_pkg::DATA_W-1:0]   m_frame_bytes,
    output logic [cantxq_pkg::COUNT_W-1:0]  m_queue_count
);

    cantxq_pkg::cmd_t    cmd;
    cantxq_pkg::status_t status;

    cantxq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_tx_idle (s_tx_idle),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cantxq_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_source_addr  (s_source_addr),
        .s_pdu_specific (s_pdu_specific),
        .s_pdu_format   (s_pdu_format),
        .s_data_page    (s_data_page),
        .s_priority_req (s_priority_req),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .s_tx_accepts   (s_tx_accepts),
        .m_frame_valid  (m_frame_valid),
        .m_frame_id     (m_frame_id),
        .m_frame_length (m_frame_length),
        .m_frame_bytes  (m_frame_bytes),
        .m_queue_count  (m_queue_count)
    );

endmodule
